// ===== rtl/core/stereo_audio_effect_chain_macros.svh =====
// Assertion macros shared by the stereo effect chain RTL.
`ifndef STEREO_AUDIO_EFFECT_CHAIN_MACROS_SVH
`define STEREO_AUDIO_EFFECT_CHAIN_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define SAEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("saec assertion failed");

// Condition in one cycle implies a consequence in the next.
`define SAEC_ASSERT_NEXT(lbl, ante, cons) \
  `SAEC_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== rtl/core/saec_pkg.sv =====
// Types, constants and saturation helpers for the stereo effect chain.
package saec_pkg;

  typedef logic signed [15:0] io_smp_t;
  typedef logic signed [19:0] smp_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME         = 3'd0,
    CFG_BASS_ENABLE    = 3'd1,
    CFG_BASS_STRENGTH  = 3'd2,
    CFG_WIDTH_ENABLE   = 3'd3,
    CFG_REVERB_ENABLE  = 3'd4,
    CFG_LIMITER_ENABLE = 3'd5
  } cfg_idx_e;

  localparam int TAP_BACK   = 800;
  localparam int DIV_BITS   = 14;     // limiter quotient always below 2^14
  localparam int DIV_IDX_W  = 4;

  localparam logic [8:0]  VOL_UNITY   = 9'd256;
  localparam logic [12:0] ALPHA_Q16   = 13'd5243;
  localparam logic [14:0] FB_Q16      = 15'd22938;
  localparam logic [15:0] LIM_K_POS   = 16'd40955;  // 5 * 8191
  localparam logic [15:0] LIM_K_NEG   = 16'd40960;  // 5 * 8192
  localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;
  localparam int          KNEE        = 24576;

  typedef struct packed {
    logic [8:0] volume;
    logic       bass_en;
    logic [3:0] bass_str;
    logic       width_en;
    logic       reverb_en;
    logic       limiter_en;
  } cfg_t;

  typedef struct packed {
    logic                 clear;
    logic                 load_in;
    logic                 vol;
    logic                 bass_a;
    logic                 bass_b;
    logic                 wid_a;
    logic                 wid_b;
    logic                 rev_a;
    logic                 rev_b;
    logic                 lim_a;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 load_out;
  } cmd_t;

  function automatic smp_t sat20(input logic signed [39:0] v);
    if (v > 40'sd524287) return 20'sd524287;
    if (v < -40'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607) return 24'sd8388607;
    if (v < -40'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic io_smp_t sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sd32767;
    if (v < -40'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/saec_ifs.sv =====
// Handshake interfaces: frame input, frame output and register writes.
interface saec_in_if;
  logic              valid;
  logic              ready;
  saec_pkg::io_smp_t left_in;
  saec_pkg::io_smp_t right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface saec_out_if;
  logic              valid;
  logic              ready;
  saec_pkg::io_smp_t left_out;
  saec_pkg::io_smp_t right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface saec_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [saec_pkg::CFG_IDX_W-1:0]       index;
  logic [saec_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/saec_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module saec_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/saec_ctrl.sv =====
// Sequencer: echo clear pass, per-frame stage steps, divider count, output valid.
`include "stereo_audio_effect_chain_macros.svh"
module saec_ctrl import saec_pkg::*; #(
  parameter int ECHO_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cmd_t                          cmd_o,
  output logic [$clog2(ECHO_DEPTH)-1:0] clr_addr_o
);
  localparam int AW = $clog2(ECHO_DEPTH);

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b000000000001,
    ST_IDLE   = 12'b000000000010,
    ST_VOL    = 12'b000000000100,
    ST_BASS_A = 12'b000000001000,
    ST_BASS_B = 12'b000000010000,
    ST_WID_A  = 12'b000000100000,
    ST_WID_B  = 12'b000001000000,
    ST_REV_A  = 12'b000010000000,
    ST_REV_B  = 12'b000100000000,
    ST_LIM_A  = 12'b001000000000,
    ST_DIV    = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [DIV_IDX_W-1:0] div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    cmd_o.div_idx = div_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (clr_cnt_q == AW'(ECHO_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_VOL;
        end
      end
      ST_VOL: begin
        cmd_o.vol = 1'b1;
        state_d   = ST_BASS_A;
      end
      ST_BASS_A: begin
        cmd_o.bass_a = 1'b1;
        state_d      = ST_BASS_B;
      end
      ST_BASS_B: begin
        cmd_o.bass_b = 1'b1;
        state_d      = ST_WID_A;
      end
      ST_WID_A: begin
        cmd_o.wid_a = 1'b1;
        state_d     = ST_WID_B;
      end
      ST_WID_B: begin
        cmd_o.wid_b = 1'b1;
        state_d     = ST_REV_A;
      end
      ST_REV_A: begin
        cmd_o.rev_a = 1'b1;
        state_d     = ST_REV_B;
      end
      ST_REV_B: begin
        cmd_o.rev_b = 1'b1;
        state_d     = ST_LIM_A;
      end
      ST_LIM_A: begin
        cmd_o.lim_a = 1'b1;
        div_cnt_d   = DIV_IDX_W'(DIV_BITS - 1);
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign clr_addr_o  = clr_cnt_q;

  `SAEC_ASSERT_NEXT(a_accept_starts_vol, in_valid_i && state_q == ST_IDLE, state_q == ST_VOL)
  `SAEC_ASSERT(a_load_out_free, cmd_o.load_out |-> (!out_valid_q || out_ready_i))
  `SAEC_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && div_cnt_q == '0, state_q == ST_DONE)
  `SAEC_ASSERT(a_no_out_during_clear, state_q == ST_CLEAR |-> !out_valid_q)
endmodule

// ===== rtl/core/saec_dp.sv =====
// Datapath: two sample lanes, filter state, echo lines, limiter divider, output regs.
module saec_dp import saec_pkg::*; #(
  parameter int ECHO_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  cmd_t                          cmd_i,
  input  logic [$clog2(ECHO_DEPTH)-1:0] clr_addr_i,
  input  io_smp_t                       left_in_i,
  input  io_smp_t                       right_in_i,
  output io_smp_t                       left_out_o,
  output io_smp_t                       right_out_o
);
  localparam int AW  = $clog2(ECHO_DEPTH);
  localparam int TAP = TAP_BACK % ECHO_DEPTH;

  typedef enum logic [1:0] {LM_PASS, LM_POS, LM_NEG} lim_mode_e;

  smp_t                    x_q      [2];
  logic signed [31:0]      bs_q     [2];
  logic signed [47:0]      prod_q   [2];
  logic signed [19:0]      mid_q;
  logic signed [24:0]      side14_q;
  logic [35:0]             rem_q    [2];
  logic [21:0]             den_q    [2];
  logic [DIV_BITS-1:0]     quo_q    [2];
  lim_mode_e               mode_q   [2];
  logic [AW-1:0]           ptr_q;
  io_smp_t                 lout_q, rout_q;

  logic [23:0]             rd       [2];
  logic signed [23:0]      ewr      [2];
  logic [AW-1:0]           tap_addr, ram_waddr;
  logic                    ram_we;

  // lane temporaries
  logic signed [29:0]      vprod    [2];
  logic signed [33:0]      bd       [2];
  logic signed [32:0]      bsum     [2];
  logic signed [31:0]      bs_new   [2];
  logic signed [36:0]      bboost   [2];
  logic signed [36:0]      bb_adj   [2];
  smp_t                    x_bass   [2];
  logic signed [25:0]      rsum     [2];
  logic signed [23:0]      radj     [2];
  smp_t                    x_rev    [2];
  logic signed [20:0]      lneg     [2];
  logic [19:0]             ld       [2];
  logic [15:0]             lk       [2];
  lim_mode_e               lmode    [2];
  logic [35:0]             trial    [2];
  io_smp_t                 lres     [2];

  // width temporaries
  logic signed [20:0]      wsum, wdif, wsum_adj, wdif_adj;
  logic signed [19:0]      wside;
  logic [23:0]             wmag;
  logic [55:0]             wqprod;
  logic signed [21:0]      wside_sc;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      vprod[l]  = x_q[l] * $signed({1'b0, cfg_i.volume});
      bd[l]     = {{6{x_q[l][19]}}, x_q[l], 8'b0} - {{2{bs_q[l][31]}}, bs_q[l]};
      bsum[l]   = {bs_q[l][31], bs_q[l]} + {prod_q[l][47], prod_q[l][47:16]};
      bs_new[l] = sat32(40'(bsum[l]));
      bboost[l] = bs_new[l] * $signed({1'b0, cfg_i.bass_str});
      // round toward zero before the divide by 1024
      bb_adj[l] = bboost[l] + $signed({27'b0, {10{bboost[l][36]}}});
      x_bass[l] = sat20(40'(x_q[l]) + 40'($signed(bb_adj[l][36:10])));
      rsum[l]   = 26'($signed({x_q[l], 4'b0})) + 26'($signed(prod_q[l][39:16]));
      ewr[l]    = sat24(40'(rsum[l]));
      radj[l]   = $signed(rd[l]) + $signed({18'b0, {6{rd[l][23]}}});
      x_rev[l]  = sat20(40'(x_q[l]) + 40'($signed(radj[l][23:6])));
      lneg[l]   = -21'(x_q[l]) - 21'sd24576;
      if (cfg_i.limiter_en && x_q[l] > 20'sd24576) begin
        lmode[l] = LM_POS;
        ld[l]    = 20'(x_q[l] - 20'sd24576);
        lk[l]    = LIM_K_POS;
      end else if (cfg_i.limiter_en && x_q[l] < -20'sd24576) begin
        lmode[l] = LM_NEG;
        ld[l]    = lneg[l][19:0];
        lk[l]    = LIM_K_NEG;
      end else begin
        lmode[l] = LM_PASS;
        ld[l]    = '0;
        lk[l]    = LIM_K_POS;
      end
      trial[l] = 36'(den_q[l]) << cmd_i.div_idx;
      case (mode_q[l])
        LM_POS:  lres[l] = sat16(40'sd24576 + 40'($signed({1'b0, quo_q[l]})));
        LM_NEG:  lres[l] = sat16(-40'sd24576 - 40'($signed({1'b0, quo_q[l]})));
        default: lres[l] = sat16(40'(x_q[l]));
      endcase
    end
  end

  always_comb begin
    wsum     = 21'(x_q[0]) + 21'(x_q[1]);
    wdif     = 21'(x_q[0]) - 21'(x_q[1]);
    wsum_adj = wsum + $signed({20'b0, wsum[20]});
    wdif_adj = wdif + $signed({20'b0, wdif[20]});
    wside    = wdif_adj[20:1];
    // |side*14| / 10 by reciprocal multiply, exact for this range
    wmag     = side14_q[24] ? 24'(-side14_q) : 24'(side14_q);
    wqprod   = wmag * RECIP_10;
    wside_sc = side14_q[24] ? -$signed({1'b0, wqprod[55:35]})
                            : $signed({1'b0, wqprod[55:35]});
  end

  always_comb begin
    if (ptr_q >= AW'(TAP)) begin
      tap_addr = ptr_q - AW'(TAP);
    end else begin
      tap_addr = ptr_q + AW'(ECHO_DEPTH - TAP);
    end
    ram_we    = cmd_i.clear || (cmd_i.rev_b && cfg_i.reverb_en);
    ram_waddr = cmd_i.clear ? clr_addr_i : ptr_q;
  end

  saec_ram #(.WIDTH(24), .DEPTH(ECHO_DEPTH)) u_echo_left (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.clear ? 24'd0 : ewr[0]),
    .raddr_i (tap_addr),
    .rdata_o (rd[0])
  );

  saec_ram #(.WIDTH(24), .DEPTH(ECHO_DEPTH)) u_echo_right (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.clear ? 24'd0 : ewr[1]),
    .raddr_i (tap_addr),
    .rdata_o (rd[1])
  );

  // filter state and echo pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q[0] <= '0;
      bs_q[1] <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.bass_b && cfg_i.bass_en) begin
        bs_q[0] <= bs_new[0];
        bs_q[1] <= bs_new[1];
      end
      if (cmd_i.rev_b && cfg_i.reverb_en) begin
        ptr_q <= (ptr_q == AW'(ECHO_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  // sample lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q[0] <= 20'(left_in_i);
      x_q[1] <= 20'(right_in_i);
    end
    if (cmd_i.wid_a) begin
      mid_q    <= wsum_adj[20:1];
      side14_q <= wside * 25'sd14;
    end
    if (cmd_i.wid_b && cfg_i.width_en) begin
      x_q[0] <= sat20(40'(mid_q) + 40'(wside_sc));
      x_q[1] <= sat20(40'(mid_q) - 40'(wside_sc));
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.vol && cfg_i.volume < VOL_UNITY) begin
        x_q[l] <= vprod[l][27:8];
      end
      if (cmd_i.bass_a) begin
        prod_q[l] <= bd[l] * $signed({1'b0, ALPHA_Q16});
      end
      if (cmd_i.bass_b && cfg_i.bass_en) begin
        x_q[l] <= x_bass[l];
      end
      if (cmd_i.rev_a) begin
        prod_q[l] <= $signed(rd[l]) * $signed({1'b0, FB_Q16});
      end
      if (cmd_i.rev_b && cfg_i.reverb_en) begin
        x_q[l] <= x_rev[l];
      end
      if (cmd_i.lim_a) begin
        mode_q[l] <= lmode[l];
        rem_q[l]  <= 36'(ld[l] * lk[l]);
        den_q[l]  <= 22'(lk[l]) + {ld[l], 2'b0};
        quo_q[l]  <= '0;
      end
      if (cmd_i.div_step && rem_q[l] >= trial[l]) begin
        rem_q[l]                <= rem_q[l] - trial[l];
        quo_q[l][cmd_i.div_idx] <= 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      lout_q <= lres[0];
      rout_q <= lres[1];
    end
  end

  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;
endmodule

// ===== rtl/core/stereo_audio_effect_chain.sv =====
// Top level of the stereo effect chain: register file, sequencer and datapath.
//
// One stereo frame per input transaction, one processed frame per output
// transaction, in order. A frame runs volume, bass boost, stereo widening,
// comb reverb and the limiter (soft knee or hard clamp) in that order; disabled
// stages pass the sample and leave their state alone. From its accept step, a
// frame runs the volume step, two bass steps, two widening steps, two reverb
// steps, the limiter setup step and the restoring divider of the limiter (one
// quotient bit per cycle, DIV_BITS bits, both channels in parallel), and then
// loads the output register; the next frame is accepted only after that load.
// The output register lets the next frame start while a result still waits on
// the output channel. After reset the two echo lines are cleared, one entry per
// cycle, over all ECHO_DEPTH entries; no input transaction is taken in that
// time, while register writes are. Register writes are always ready and should
// only be made while no frame is in flight.
module stereo_audio_effect_chain import saec_pkg::*; #(
  parameter int ECHO_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  saec_in_if.sink    in_i,
  saec_out_if.source out_o,
  saec_cfg_if.sink   cfg_i
);
  localparam int AW = $clog2(ECHO_DEPTH);

  cfg_t          cfg_q;
  cmd_t          cmd;
  logic [AW-1:0] clr_addr;

  // Register file; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume     <= VOL_UNITY;
      cfg_q.bass_en    <= 1'b0;
      cfg_q.bass_str   <= '0;
      cfg_q.width_en   <= 1'b0;
      cfg_q.reverb_en  <= 1'b0;
      cfg_q.limiter_en <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VOLUME:         cfg_q.volume     <= cfg_i.data;
        CFG_BASS_ENABLE:    cfg_q.bass_en    <= cfg_i.data[0];
        CFG_BASS_STRENGTH:  cfg_q.bass_str   <= cfg_i.data[3:0];
        CFG_WIDTH_ENABLE:   cfg_q.width_en   <= cfg_i.data[0];
        CFG_REVERB_ENABLE:  cfg_q.reverb_en  <= cfg_i.data[0];
        CFG_LIMITER_ENABLE: cfg_q.limiter_en <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns the handshakes and steps the datapath.
  saec_ctrl #(.ECHO_DEPTH(ECHO_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .clr_addr_o  (clr_addr)
  );

  // Datapath: both channels side by side, echo RAMs inside.
  saec_dp #(.ECHO_DEPTH(ECHO_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .clr_addr_i  (clr_addr),
    .left_in_i   (in_i.left_in),
    .right_in_i  (in_i.right_in),
    .left_out_o  (out_o.left_out),
    .right_out_o (out_o.right_out)
  );
endmodule

// ===== tb/sv/stereo_audio_effect_chain_tb.sv =====
// Self-checking testbench for the stereo effect chain: random frames, register phases.
module stereo_audio_effect_chain_tb;
  import saec_pkg::*;

  localparam int DEPTH  = 1024;
  localparam int TAP_OFS = 800;
  localparam int SETTLE = 40;   // settle time after drain, covers a frame still in flight

  typedef struct {
    io_smp_t l;
    io_smp_t r;
  } frame_t;

  logic clk_i;
  logic rst_ni;

  saec_in_if  in_bus();
  saec_out_if out_bus();
  saec_cfg_if cfg_bus();

  stereo_audio_effect_chain #(.ECHO_DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the register file and of the effect state.
  logic [8:0]  sh_volume;
  logic        sh_bass_en;
  logic [3:0]  sh_bass_str;
  logic        sh_width_en;
  logic        sh_reverb_en;
  logic        sh_limiter_en;
  longint      lp_state[2];
  longint      echo_mem[2][DEPTH];
  int          echo_wp;

  frame_t pending_frames[$];
  frame_t expected_frames[$];

  int  mismatches;
  int  frames_sent;
  int  frames_checked;
  int  cfg_writes;
  bit  idle_on;
  int  in_gap;
  int  out_gap;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic io_smp_t soft_limit(longint s, bit en);
    longint d;
    longint res;
    res = s;
    if (en && s > KNEE) begin
      d = s - KNEE;
      res = KNEE + (8191 * 5 * d) / (5 * 8191 + 4 * d);
    end else if (en && s < -KNEE) begin
      d = -s - KNEE;
      res = -KNEE - (8192 * 5 * d) / (5 * 8192 + 4 * d);
    end
    return io_smp_t'(clip(res, -32768, 32767));
  endfunction

  // Runs one frame through the shadow chain, updating filter and echo state.
  task automatic process_frame(input frame_t fin, output frame_t fout);
    longint x[2];
    longint d, s, mid, side, delayed, e;
    int tap;
    x[0] = fin.l;
    x[1] = fin.r;
    for (int c = 0; c < 2; c++) begin
      if (sh_volume < 9'd256) x[c] = (x[c] * longint'(sh_volume)) >>> 8;
      if (sh_bass_en) begin
        d = x[c] * 256 - lp_state[c];
        s = clip(lp_state[c] + ((d * 5243) >>> 16), -64'sd2147483648, 64'sd2147483647);
        lp_state[c] = s;
        x[c] = clip(x[c] + (s * longint'(sh_bass_str)) / 1024, -524288, 524287);
      end
    end
    if (sh_width_en) begin
      mid  = (x[0] + x[1]) / 2;
      side = (x[0] - x[1]) / 2;
      side = (side * 14) / 10;
      x[0] = clip(mid + side, -524288, 524287);
      x[1] = clip(mid - side, -524288, 524287);
    end
    if (sh_reverb_en) begin
      tap = (echo_wp + DEPTH - TAP_OFS) % DEPTH;
      for (int c = 0; c < 2; c++) begin
        delayed = echo_mem[c][tap];
        e = x[c] * 16 + ((delayed * 22938) >>> 16);
        echo_mem[c][echo_wp] = clip(e, -8388608, 8388607);
        x[c] = clip(x[c] + delayed / 64, -524288, 524287);
      end
      echo_wp = (echo_wp + 1) % DEPTH;
    end
    fout.l = soft_limit(x[0], sh_limiter_en);
    fout.r = soft_limit(x[1], sh_limiter_en);
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Frame driver: every accepted transaction is predicted right away.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t f, exp_f;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        f.l = in_bus.left_in;
        f.r = in_bus.right_in;
        process_frame(f, exp_f);
        expected_frames.push_back(exp_f);
        frames_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          f = pending_frames.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.left_in  <= f.l;
          in_bus.right_in <= f.r;
          in_gap = pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with randomly stalling ready.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t exp_f;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transaction: L=%0d R=%0d",
                     out_bus.left_out, out_bus.right_out);
        end else begin
          exp_f = expected_frames.pop_front();
          frames_checked++;
          if (exp_f.l !== out_bus.left_out || exp_f.r !== out_bus.right_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                       frames_checked, exp_f.l, exp_f.r,
                       out_bus.left_out, out_bus.right_out);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Register shadow follows every write transaction; unknown indexes are dropped.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      cfg_writes++;
      case (cfg_bus.index)
        CFG_VOLUME:         sh_volume     = cfg_bus.data;
        CFG_BASS_ENABLE:    sh_bass_en    = cfg_bus.data[0];
        CFG_BASS_STRENGTH:  sh_bass_str   = cfg_bus.data[3:0];
        CFG_WIDTH_ENABLE:   sh_width_en   = cfg_bus.data[0];
        CFG_REVERB_ENABLE:  sh_reverb_en  = cfg_bus.data[0];
        CFG_LIMITER_ENABLE: sh_limiter_en = cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  // Writes a batch of registers back to back; valid stays high across the batch.
  task automatic write_regs(input logic [2:0] idx[], input logic [8:0] val[]);
    foreach (idx[k]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Sender holds off until the chain has drained completely.
  task automatic drain();
    while (pending_frames.size() > 0 || expected_frames.size() > 0 || in_bus.valid)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_frame(input int l, input int r);
    frame_t f;
    f.l = io_smp_t'(l);
    f.r = io_smp_t'(r);
    pending_frames.push_back(f);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 400)) - 200;
      2: return int'($urandom_range(0, 4000)) + 24000;
      default: return int'(io_smp_t'($urandom));
    endcase
  endfunction

  initial begin
    logic [2:0] idx[];
    logic [8:0] val[];
    int lens[8];
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.left_in = '0;
    in_bus.right_in = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    mismatches = 0;
    frames_sent = 0;
    frames_checked = 0;
    cfg_writes = 0;
    idle_on = 1'b1;
    sh_volume = 9'd256;
    sh_bass_en = 0;
    sh_bass_str = 0;
    sh_width_en = 0;
    sh_reverb_en = 0;
    sh_limiter_en = 0;
    lp_state[0] = 0;
    lp_state[1] = 0;
    echo_wp = 0;
    foreach (echo_mem[c, i]) echo_mem[c][i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: plain clamp path, full-scale and edge samples.
    push_frame(32767, -32768);
    push_frame(-32768, 32767);
    push_frame(0, -1);
    push_frame(24576, -24576);
    push_frame(24577, -24577);
    push_frame(1, 0);
    push_frame(-21846, 21845);
    drain();

    // Every stage on, volume above unity, strongest bass, soft limiter;
    // indexes past the register list must be ignored.
    idx = '{CFG_VOLUME, CFG_BASS_ENABLE, CFG_BASS_STRENGTH, CFG_WIDTH_ENABLE,
            CFG_REVERB_ENABLE, CFG_LIMITER_ENABLE, 3'd6, 3'd7};
    val = '{9'd511, 9'd1, 9'd15, 9'd1, 9'd1, 9'd1, 9'd0, 9'h1FF};
    write_regs(idx, val);
    for (int i = 0; i < 6; i++) push_frame(32767, 32767);
    for (int i = 0; i < 6; i++) push_frame(-32768, -32768);
    push_frame(32767, -32768);
    push_frame(-32768, 32767);
    push_frame(0, 0);
    push_frame(24577, -24577);
    drain();

    // Random phases; reverb is mostly on so the tap reaches written entries.
    lens = '{40, 220, 200, 180, 160, 160, 150, 140};
    for (int p = 0; p < 8; p++) begin
      idle_on = (p != 3);
      idx = '{CFG_VOLUME, CFG_BASS_ENABLE, CFG_BASS_STRENGTH, CFG_WIDTH_ENABLE,
              CFG_REVERB_ENABLE, CFG_LIMITER_ENABLE};
      val = new[6];
      case (p)
        0: val[0] = 9'd0;
        1: val[0] = 9'd256;
        2: val[0] = 9'd255;
        3: val[0] = 9'd511;
        default: val[0] = 9'($urandom_range(0, 511));
      endcase
      val[1] = 9'($urandom_range(0, 1));
      val[2] = (p == 2) ? 9'd0 : (p == 5) ? 9'd15 : 9'($urandom_range(0, 15));
      val[3] = 9'($urandom_range(0, 1));
      val[4] = ($urandom_range(0, 3) != 0) ? 9'd1 : 9'd0;
      val[5] = 9'($urandom_range(0, 1));
      write_regs(idx, val);
      for (int i = 0; i < lens[p]; i++) push_frame(rand_sample(), rand_sample());
      drain();
    end

    $display("%0d frames sent, %0d checked over 10 register phases, %0d register writes",
             frames_sent, frames_checked, cfg_writes);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d frames still expected", expected_frames.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
